// ----- rtl/lzss_stream_decompressor_unit_defines.svh -----
// ----------------------------------------------------------------------------
// LZSS decompressor assertion macros
// Shared concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef LZSS_STREAM_DECOMPRESSOR_UNIT_DEFINES_SVH
`define LZSS_STREAM_DECOMPRESSOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define LZSS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define LZSS_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LZSS_ASSERT(lbl, clk, rst_n, prop, msg)
`define LZSS_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- rtl/lzss_pkg.sv -----
// ----------------------------------------------------------------------------
// LZSS decompressor package
// Shared constants, request/result types, token command type and header magic bytes.
// ----------------------------------------------------------------------------
package lzss_pkg;

    localparam int WINDOW_SIZE  = 4096;
    localparam int MAX_MATCH    = 18;
    localparam int HEADER_BYTES = 16;
    localparam int MIN_MATCH    = MAX_MATCH - 15;
    localparam int WIN_AW       = $clog2(WINDOW_SIZE);
    localparam int LEN_W        = $clog2(MAX_MATCH + 1);

    localparam logic [WIN_AW-1:0] WIN_START  = WIN_AW'(WINDOW_SIZE - MAX_MATCH);
    localparam logic [7:0]        BLANK_BYTE = 8'h20;

    localparam logic STATUS_DATA = 1'b0;
    localparam logic STATUS_RAW  = 1'b1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_of_stream;
    } in_req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       status;
        logic       last_of_run;
    } out_res_t;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_STATUS  = 2'd1,
        CMD_LITERAL = 2'd2,
        CMD_MATCH   = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [7:0]        data;
        logic [WIN_AW-1:0] pos;
        logic [LEN_W-1:0]  len;
    } cmd_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = 8'hFF;
            2'd1: b = 8'h57;
            2'd2: b = 8'h50;
            2'd3: b = 8'h43;
            default: b = 8'hFF;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/lzss_win.sv -----
// ----------------------------------------------------------------------------
// LZSS window store
// 4096-byte history memory with write pointer, fill count and forwarding.
// ----------------------------------------------------------------------------
`include "lzss_stream_decompressor_unit_defines.svh"

module lzss_win (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       restart,
    input  logic                       wr_en,
    input  logic [7:0]                 wr_data,
    input  logic                       rd_en,
    input  logic [lzss_pkg::WIN_AW-1:0] rd_addr,
    output logic [7:0]                 rd_data
);
    import lzss_pkg::*;

    logic [7:0]        mem [WINDOW_SIZE];
    logic [7:0]        rd_q_reg;
    logic [WIN_AW-1:0] wp_reg, wp_next;
    logic [WIN_AW:0]   fill_reg, fill_next;
    logic              fwd_reg, blank_reg;
    logic [7:0]        fwd_data_reg;
    logic [WIN_AW-1:0] rd_ofs;
    logic              hit, blank;

    // Entries outside the span written since restart still read as spaces.
    assign rd_ofs = rd_addr - WIN_START;
    assign hit    = wr_en && (rd_addr == wp_reg);
    assign blank  = !hit && ({1'b0, rd_ofs} >= fill_reg);

    always_comb
    begin
        wp_next   = wp_reg;
        fill_next = fill_reg;
        if (restart)
        begin
            wp_next   = WIN_START;
            fill_next = '0;
        end
        else if (wr_en)
        begin
            wp_next = wp_reg + 1'b1;
            if (fill_reg != (WIN_AW+1)'(WINDOW_SIZE))
                fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= WIN_START;
            fill_reg <= '0;
        end
        else
        begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= wr_data;
        if (rd_en)
        begin
            rd_q_reg     <= mem[rd_addr];
            fwd_reg      <= hit;
            blank_reg    <= blank;
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : (blank_reg ? BLANK_BYTE : rd_q_reg);

    `LZSS_NEVER(a_fill_range, clk, rst_n, fill_reg > (WIN_AW+1)'(WINDOW_SIZE), "fill count overflow")
    `LZSS_NEVER(a_restart_wr, clk, rst_n, restart && wr_en, "window write during restart")
    `LZSS_ASSERT(a_wp_track, clk, rst_n, $past(wr_en) && !$past(restart) |-> wp_reg == $past(wp_reg) + 1'b1, "write pointer skipped")

endmodule

// ----- rtl/lzss_parse.sv -----
// ----------------------------------------------------------------------------
// LZSS byte parser
// Tracks header, flag bits and token bytes; issues one command per byte.
// ----------------------------------------------------------------------------
module lzss_parse #(
    parameter int HEADER_BYTES = lzss_pkg::HEADER_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  lzss_pkg::in_req_t req,
    output lzss_pkg::cmd_t    cmd
);
    import lzss_pkg::*;

    localparam int HC_W = $clog2(HEADER_BYTES + 1);

    logic [HC_W-1:0] hcnt_reg, hcnt_next, hcnt_eff;
    logic            magic_reg, magic_next, magic_eff;
    logic            await_reg, await_next, await_eff;
    logic [7:0]      first_reg, first_next, first_eff;
    logic [15:0]     flag_reg, flag_next, flag_eff;
    logic            rej_reg, rej_next, rej_eff;
    logic [7:0]      b;

    assign b = req.in_byte;

    // A start byte sees the fresh-stream state.
    always_comb
    begin
        if (req.start_of_stream)
        begin
            hcnt_eff  = '0;
            magic_eff = 1'b1;
            await_eff = 1'b0;
            first_eff = '0;
            flag_eff  = '0;
            rej_eff   = 1'b0;
        end
        else
        begin
            hcnt_eff  = hcnt_reg;
            magic_eff = magic_reg;
            await_eff = await_reg;
            first_eff = first_reg;
            flag_eff  = flag_reg;
            rej_eff   = rej_reg;
        end
    end

    always_comb
    begin
        hcnt_next  = hcnt_eff;
        magic_next = magic_eff;
        await_next = await_eff;
        first_next = first_eff;
        flag_next  = flag_eff;
        rej_next   = rej_eff;
        cmd.kind   = CMD_NONE;
        cmd.data   = b;
        cmd.pos    = {b[7:4], first_eff};
        cmd.len    = LEN_W'({1'b0, b[3:0]}) + LEN_W'(MIN_MATCH);
        priority if (rej_eff)
        begin
            cmd.kind = CMD_NONE;
        end
        else if (hcnt_eff < HC_W'(HEADER_BYTES))
        begin
            if ((hcnt_eff < HC_W'(4)) && (b != magic_byte(hcnt_eff[1:0])))
                magic_next = 1'b0;
            if ((hcnt_eff == HC_W'(3)) && !magic_next)
            begin
                rej_next = 1'b1;
                cmd.kind = CMD_STATUS;
            end
            hcnt_next = hcnt_eff + 1'b1;
        end
        else if (await_eff)
        begin
            cmd.kind   = CMD_MATCH;
            await_next = 1'b0;
            flag_next  = flag_eff >> 1;
        end
        else if (!flag_eff[8])
        begin
            flag_next = 16'hFF00 | {8'h00, b};
        end
        else if (flag_eff[0])
        begin
            cmd.kind  = CMD_LITERAL;
            flag_next = flag_eff >> 1;
        end
        else
        begin
            first_next = b;
            await_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hcnt_reg  <= '0;
            magic_reg <= 1'b1;
            await_reg <= 1'b0;
            first_reg <= '0;
            flag_reg  <= '0;
            rej_reg   <= 1'b0;
        end
        else if (take)
        begin
            hcnt_reg  <= hcnt_next;
            magic_reg <= magic_next;
            await_reg <= await_next;
            first_reg <= first_next;
            flag_reg  <= flag_next;
            rej_reg   <= rej_next;
        end
    end

endmodule

// ----- rtl/lzss_stream_decompressor_unit.sv -----
// ----------------------------------------------------------------------------
// LZSS stream decompressor unit
// Decodes a headered LZSS byte stream against a 4096-byte window memory.
// ----------------------------------------------------------------------------
//  Channel | Handshake                | Payload
//  --------+--------------------------+------------------------------------
//  comp    | comp_valid / comp_stall  | in_req_t: in_byte, start_of_stream
//  plain   | plain_valid / plain_stall| out_res_t: out_byte, status, last_of_run
//
//  Header, flag, first-match and literal requests complete on acceptance.
//  A match request copies 3 to 18 bytes, one per cycle while the queue has
//  room, through the window memory read port (each byte read is written back
//  in the cycle after); the next request is taken only after the copy: the
//  accept, the len reads and the last write-back.
//  Reset and start_of_stream need no window clearing: a fill count marks which
//  entries were written since the start, the rest read as spaces.
//  A stall on plain pauses the copy once the 4-entry result queue is full.
// ----------------------------------------------------------------------------
`include "lzss_stream_decompressor_unit_defines.svh"

module lzss_stream_decompressor_unit #(
    parameter int HEADER_BYTES = lzss_pkg::HEADER_BYTES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               comp_valid,
    output logic               comp_stall,
    input  lzss_pkg::in_req_t  comp,
    output logic               plain_valid,
    input  logic               plain_stall,
    output lzss_pkg::out_res_t plain
);
    import lzss_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_COPY = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [WIN_AW-1:0] src_reg, src_next;
    logic [LEN_W-1:0]  left_reg, left_next;
    logic              s2_vld_reg, s2_vld_next;
    logic              s2_last_reg, s2_last_next;

    out_res_t          q_mem [QDEPTH];
    logic [QAW-1:0]    q_wp_reg, q_rp_reg;
    logic [QAW:0]      q_cnt_reg, q_cnt_next;

    cmd_t              cmd;
    logic              accept, issue, push, pop, win_wr;
    logic [7:0]        win_rd_data, win_wr_data;
    out_res_t          push_res;

    // Take a request only with the copy path drained and a queue slot free.
    assign comp_stall = !((state_reg == ST_IDLE) && !s2_vld_reg &&
                          (q_cnt_reg != (QAW+1)'(QDEPTH)));
    assign accept     = comp_valid && !comp_stall;

    // Issue a window read only if its byte is sure of a queue slot next cycle.
    assign issue = (state_reg == ST_COPY) &&
                   ((q_cnt_reg + (QAW+1)'(s2_vld_reg)) < (QAW+1)'(QDEPTH));

    lzss_parse #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (accept),
        .req   (comp),
        .cmd   (cmd)
    );

    assign win_wr      = s2_vld_reg || (accept && (cmd.kind == CMD_LITERAL));
    assign win_wr_data = s2_vld_reg ? win_rd_data : cmd.data;

    lzss_win u_win (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (accept && comp.start_of_stream),
        .wr_en   (win_wr),
        .wr_data (win_wr_data),
        .rd_en   (issue),
        .rd_addr (src_reg),
        .rd_data (win_rd_data)
    );

    // Copy sequencer: load source and length on an accepted match, then advance them on each issued read.
    always_comb
    begin
        state_next   = state_reg;
        src_next     = src_reg;
        left_next    = left_reg;
        s2_vld_next  = issue;
        s2_last_next = s2_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.kind == CMD_MATCH))
                begin
                    src_next   = cmd.pos;
                    left_next  = cmd.len;
                    state_next = ST_COPY;
                end
            end
            ST_COPY:
            begin
                if (issue)
                begin
                    src_next     = src_reg + 1'b1;
                    left_next    = left_reg - 1'b1;
                    s2_last_next = (left_reg == LEN_W'(1));
                    if (left_reg == LEN_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            s2_vld_reg <= s2_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg     <= src_next;
        left_reg    <= left_next;
        s2_last_reg <= s2_last_next;
    end

    // Result queue: copied bytes, literals and the not-compressed status.
    always_comb
    begin
        push     = 1'b0;
        push_res = '{out_byte: win_rd_data, status: STATUS_DATA, last_of_run: s2_last_reg};
        if (s2_vld_reg)
        begin
            push = 1'b1;
        end
        else if (accept && (cmd.kind == CMD_LITERAL))
        begin
            push     = 1'b1;
            push_res = '{out_byte: cmd.data, status: STATUS_DATA, last_of_run: 1'b1};
        end
        else if (accept && (cmd.kind == CMD_STATUS))
        begin
            push     = 1'b1;
            push_res = '{out_byte: 8'h00, status: STATUS_RAW, last_of_run: 1'b1};
        end
    end

    assign plain_valid = (q_cnt_reg != '0);
    assign plain       = q_mem[q_rp_reg];
    assign pop         = plain_valid && !plain_stall;

    always_comb
    begin
        q_cnt_next = q_cnt_reg;
        if (push && !pop)
            q_cnt_next = q_cnt_reg + 1'b1;
        else if (pop && !push)
            q_cnt_next = q_cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wp_reg  <= '0;
            q_rp_reg  <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            if (push)
                q_wp_reg <= q_wp_reg + 1'b1;
            if (pop)
                q_rp_reg <= q_rp_reg + 1'b1;
            q_cnt_reg <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[q_wp_reg] <= push_res;
    end

    `LZSS_NEVER(a_q_overflow, clk, rst_n, s2_vld_reg && (q_cnt_reg == (QAW+1)'(QDEPTH)), "copied byte with full queue")
    `LZSS_NEVER(a_q_range, clk, rst_n, q_cnt_reg > (QAW+1)'(QDEPTH), "queue count out of range")
    `LZSS_ASSERT(a_copy_len, clk, rst_n, (state_reg == ST_COPY) |-> (left_reg != '0), "copy with no bytes left")
    `LZSS_ASSERT(a_last_idle, clk, rst_n, (s2_vld_reg && s2_last_reg) |-> (state_reg == ST_IDLE), "last copy byte while copy still running")

endmodule
